>>> hw/rtl/vcsd_pkg.sv
// Shared types and constants for the VGM command stream decoder.
`default_nettype none
package vcsd_pkg;

   localparam int unsigned CMD_QUEUE_DEPTH_DEF = 4;
   localparam int unsigned RSP_QUEUE_DEPTH_DEF = 2;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [1:0] REG_FORMAT_VERSION = 2'd0;
   localparam logic [1:0] REG_DATA_OFFSET    = 2'd1;
   localparam logic [1:0] REG_LOOP_OFFSET    = 2'd2;

   localparam logic [15:0] VER_NEW_START    = 16'h0150;
   localparam logic [15:0] VER_EXT_OPERANDS = 16'h0160;
   localparam logic [31:0] DATA_START_OLD   = 32'h0000_0040;
   localparam logic [31:0] DATA_START_BIAS  = 32'h0000_0034;
   localparam logic [31:0] LOOP_BIAS        = 32'h0000_001c;

   localparam logic [7:0] BYTE_END     = 8'h66;
   localparam logic [7:0] OP_PSG       = 8'h50;
   localparam logic [7:0] OP_FM0       = 8'h52;
   localparam logic [7:0] OP_FM1       = 8'h53;
   localparam logic [7:0] OP_WAIT_N    = 8'h61;
   localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
   localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
   localparam logic [7:0] OP_BLOCK     = 8'h67;
   localparam logic [7:0] OP_SKIP_LONG = 8'h68;
   localparam logic [7:0] OP_PCM_SEEK  = 8'he0;

   localparam logic [15:0] WAIT_NTSC = 16'h02df;
   localparam logic [15:0] WAIT_PAL  = 16'h0372;

   localparam logic [3:0] CMD_PSG         = 4'd0;
   localparam logic [3:0] CMD_FM          = 4'd1;
   localparam logic [3:0] CMD_WAIT        = 4'd2;
   localparam logic [3:0] CMD_FM_PCM_WAIT = 4'd3;
   localparam logic [3:0] CMD_DATA_BLOCK  = 4'd4;
   localparam logic [3:0] CMD_PCM_SEEK    = 4'd5;
   localparam logic [3:0] CMD_END         = 4'd6;
   localparam logic [3:0] CMD_LOOP        = 4'd7;
   localparam logic [3:0] CMD_BAD_OPCODE  = 4'd8;

   typedef enum logic [2:0] {
      CLS_END,
      CLS_SKIP,
      CLS_OPERANDS,
      CLS_WAIT_LONG,
      CLS_WAIT_SHORT,
      CLS_PCM_WAIT,
      CLS_BAD
   } cls_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      cls_type    cls;
      logic [3:0] count;
   } cmd_entry_type;

   typedef struct packed {
      logic        ext_operands;
      logic        loop_enabled;
      logic [31:0] data_start;
      logic [31:0] loop_index;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  command;
      logic        chip_port;
      logic [7:0]  reg_address;
      logic [7:0]  reg_data;
      logic [15:0] wait_count;
      logic [31:0] wide_value;
      logic [31:0] block_position;
   } rsp_type;

endpackage
`default_nettype wire

>>> hw/rtl/vcsd_queue.sv
// Small register-based FIFO used between front and back and on the result side.
`default_nettype none
module vcsd_queue #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/vcsd_front.sv
// Front end: accepts requests and classifies each stream byte.
`default_nettype none
module vcsd_front (
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic                    req_kind,
   input  wire logic [7:0]              req_byte_value,
   input  wire logic                    ext_operands,
   input  wire logic                    q_full,
   output logic                         q_push,
   output vcsd_pkg::cmd_entry_type      q_data
);
   import vcsd_pkg::*;

   cls_type    cls;
   logic [3:0] count;
   logic [7:0] b;

   assign b = req_byte_value;

   always_comb begin
      cls   = CLS_BAD;
      count = 4'd0;
      if (b == BYTE_END) begin
         cls = CLS_END;
      end else if (b >= 8'h40 && b <= 8'h4e && ext_operands) begin
         cls   = CLS_SKIP;
         count = 4'd2;
      end else if (b >= 8'h30 && b <= 8'h4f) begin
         cls   = CLS_SKIP;
         count = 4'd1;
      end else if (b >= 8'ha0 && b <= 8'hbf) begin
         cls   = CLS_SKIP;
         count = 4'd2;
      end else if (b >= 8'hc0 && b <= 8'hdf) begin
         cls   = CLS_SKIP;
         count = 4'd3;
      end else if (b >= 8'he1) begin
         cls   = CLS_SKIP;
         count = 4'd4;
      end else if (b == OP_SKIP_LONG) begin
         cls   = CLS_SKIP;
         count = 4'd11;
      end else if (b == OP_PSG) begin
         cls   = CLS_OPERANDS;
         count = 4'd1;
      end else if (b == OP_FM0 || b == OP_FM1 || b == OP_WAIT_N) begin
         cls   = CLS_OPERANDS;
         count = 4'd2;
      end else if (b == OP_PCM_SEEK) begin
         cls   = CLS_OPERANDS;
         count = 4'd4;
      end else if (b == OP_BLOCK) begin
         cls   = CLS_OPERANDS;
         count = 4'd6;
      end else if (b == OP_WAIT_NTSC || b == OP_WAIT_PAL) begin
         cls = CLS_WAIT_LONG;
      end else if (b >= 8'h70 && b <= 8'h7f) begin
         cls = CLS_WAIT_SHORT;
      end else if (b >= 8'h80 && b <= 8'h8f) begin
         cls = CLS_PCM_WAIT;
      end
   end

   assign req_full            = q_full;
   assign q_push              = req_push && !q_full;
   assign q_data.kind         = req_kind;
   assign q_data.byte_value   = req_byte_value;
   assign q_data.cls          = cls;
   assign q_data.count        = count;

endmodule
`default_nettype wire

>>> hw/rtl/vcsd_back.sv
// Back end: parser state, operand collection, payload skipping and result build.
`default_nettype none
module vcsd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire vcsd_pkg::cfg_type       cfg,
   input  wire logic                    cmd_empty,
   input  wire vcsd_pkg::cmd_entry_type cmd_data,
   output logic                         cmd_pop,
   input  wire logic                    rsp_full,
   output logic                         rsp_push,
   output vcsd_pkg::rsp_type            rsp_data
);
   import vcsd_pkg::*;

   typedef enum logic [1:0] {
      PH_OPCODE,
      PH_OPERANDS,
      PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  op_ff, op_in;
   logic [2:0]  needed_ff, needed_in;
   logic [2:0]  count_ff, count_in;
   logic [47:0] shift_ff, shift_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] pos_ff, pos_in;
   logic        finished_ff, finished_in;

   logic        take;
   logic        produce;
   logic        do_end;
   logic [47:0] merged;
   logic [2:0]  count_next;
   logic [7:0]  b;

   assign take       = !cmd_empty && !rsp_full;
   assign cmd_pop    = take;
   assign rsp_push   = take && produce;
   assign b          = cmd_data.byte_value;
   assign merged     = shift_ff | (48'(b) << {count_ff, 3'b000});
   assign count_next = count_ff + 3'd1;

   always_comb begin
      phase_in    = phase_ff;
      op_in       = op_ff;
      needed_in   = needed_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      skip_in     = skip_ff;
      pos_in      = pos_ff;
      finished_in = finished_ff;
      produce     = 1'b0;
      do_end      = 1'b0;
      rsp_data    = '0;
      if (take && !finished_ff) begin
         if (cmd_data.kind) begin
            do_end = 1'b1;
         end else begin
            pos_in = pos_ff + 32'd1;
            case (phase_ff)
               PH_SKIP: begin
                  skip_in = skip_ff - 32'd1;
                  if (skip_ff == 32'd1) begin
                     phase_in = PH_OPCODE;
                  end
               end
               PH_OPERANDS: begin
                  shift_in = merged;
                  count_in = count_next;
                  if (count_next == needed_ff) begin
                     phase_in = PH_OPCODE;
                     count_in = '0;
                     shift_in = '0;
                     case (op_ff)
                        OP_PSG: begin
                           produce           = 1'b1;
                           rsp_data.command  = CMD_PSG;
                           rsp_data.reg_data = merged[7:0];
                        end
                        OP_FM0, OP_FM1: begin
                           produce              = 1'b1;
                           rsp_data.command     = CMD_FM;
                           rsp_data.chip_port   = op_ff[0];
                           rsp_data.reg_address = merged[7:0];
                           rsp_data.reg_data    = merged[15:8];
                        end
                        OP_WAIT_N: begin
                           produce             = 1'b1;
                           rsp_data.command    = CMD_WAIT;
                           rsp_data.wait_count = merged[15:0];
                        end
                        OP_PCM_SEEK: begin
                           produce             = 1'b1;
                           rsp_data.command    = CMD_PCM_SEEK;
                           rsp_data.wide_value = merged[31:0];
                        end
                        default: begin
                           if (merged[47:16] != 32'd0) begin
                              skip_in  = merged[47:16];
                              phase_in = PH_SKIP;
                           end
                           if (merged[15:8] == 8'd0) begin
                              produce                 = 1'b1;
                              rsp_data.command        = CMD_DATA_BLOCK;
                              rsp_data.wide_value     = merged[47:16];
                              rsp_data.block_position = cfg.data_start + pos_in;
                           end
                        end
                     endcase
                  end
               end
               default: begin
                  case (cmd_data.cls)
                     CLS_END: begin
                        do_end = 1'b1;
                     end
                     CLS_SKIP: begin
                        skip_in  = 32'(cmd_data.count);
                        phase_in = PH_SKIP;
                     end
                     CLS_OPERANDS: begin
                        op_in     = b;
                        needed_in = cmd_data.count[2:0];
                        count_in  = '0;
                        shift_in  = '0;
                        phase_in  = PH_OPERANDS;
                     end
                     CLS_WAIT_LONG: begin
                        produce             = 1'b1;
                        rsp_data.command    = CMD_WAIT;
                        rsp_data.wait_count = (b == OP_WAIT_PAL) ? WAIT_PAL : WAIT_NTSC;
                     end
                     CLS_WAIT_SHORT: begin
                        produce             = 1'b1;
                        rsp_data.command    = CMD_WAIT;
                        rsp_data.wait_count = 16'(b[3:0]);
                     end
                     CLS_PCM_WAIT: begin
                        produce             = 1'b1;
                        rsp_data.command    = CMD_FM_PCM_WAIT;
                        rsp_data.wait_count = 16'(b[3:0]);
                     end
                     default: begin
                        produce          = 1'b1;
                        finished_in      = 1'b1;
                        rsp_data.command = CMD_BAD_OPCODE;
                        op_in            = '0;
                        count_in         = '0;
                        shift_in         = '0;
                        skip_in          = '0;
                        phase_in         = PH_OPCODE;
                     end
                  endcase
               end
            endcase
         end
         if (do_end) begin
            phase_in = PH_OPCODE;
            op_in    = '0;
            count_in = '0;
            shift_in = '0;
            skip_in  = '0;
            produce  = 1'b1;
            rsp_data = '0;
            if (!cfg.loop_enabled) begin
               finished_in      = 1'b1;
               rsp_data.command = CMD_END;
            end else begin
               pos_in              = cfg.loop_index;
               rsp_data.command    = CMD_LOOP;
               rsp_data.wide_value = cfg.loop_index;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OPCODE;
         op_ff       <= '0;
         needed_ff   <= '0;
         count_ff    <= '0;
         shift_ff    <= '0;
         skip_ff     <= '0;
         pos_ff      <= '0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         op_ff       <= op_in;
         needed_ff   <= needed_in;
         count_ff    <= count_in;
         shift_ff    <= shift_in;
         skip_ff     <= skip_in;
         pos_ff      <= pos_in;
         finished_ff <= finished_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/vgm_command_stream_decoder.sv
// Top level of the VGM command stream decoder: CSR block, front, queues and back.
// Taken requests are registered in the command queue, results in the result queue.
// Throughput: one request per cycle while no queue is full, set by the back-end parser.
// The command queue between front and back lets either side stall on its own.
// Reset (synchronous): CSR registers to zero, parser to expect opcode, queues empty.
`default_nettype none
module vgm_command_stream_decoder #(
   parameter int unsigned CMD_QUEUE_DEPTH = vcsd_pkg::CMD_QUEUE_DEPTH_DEF,
   parameter int unsigned RSP_QUEUE_DEPTH = vcsd_pkg::RSP_QUEUE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic                            req_kind,
   input  wire logic [7:0]                      req_byte_value,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [3:0]                           rsp_command,
   output logic                                 rsp_chip_port,
   output logic [7:0]                           rsp_reg_address,
   output logic [7:0]                           rsp_reg_data,
   output logic [15:0]                          rsp_wait_count,
   output logic [31:0]                          rsp_wide_value,
   output logic [31:0]                          rsp_block_position,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [vcsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [vcsd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vcsd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import vcsd_pkg::*;

   logic [15:0] version_ff;
   logic [31:0] data_off_ff;
   logic [31:0] loop_off_ff;
   logic [31:0] data_start_ff, data_start_in;
   logic [31:0] loop_index_ff, loop_index_in;
   logic        csr_write;
   logic [1:0]  csr_index;
   cfg_type     cfg;

   cmd_entry_type front_data, cmd_data;
   logic          front_push, cmd_full, cmd_empty, cmd_pop;
   rsp_type       back_data, rsp_data;
   logic          back_push, rsp_full;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      case (csr_index)
         REG_FORMAT_VERSION: csr_prdata = 32'(version_ff);
         REG_DATA_OFFSET:    csr_prdata = data_off_ff;
         REG_LOOP_OFFSET:    csr_prdata = loop_off_ff;
         default:            csr_prdata = '0;
      endcase
   end

   assign data_start_in = (version_ff < VER_NEW_START) ? DATA_START_OLD
                                                       : data_off_ff + DATA_START_BIAS;
   assign loop_index_in = loop_off_ff + LOOP_BIAS - data_start_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff    <= '0;
         data_off_ff   <= '0;
         loop_off_ff   <= '0;
         data_start_ff <= DATA_START_OLD;
         loop_index_ff <= LOOP_BIAS - DATA_START_OLD;
      end else begin
         data_start_ff <= data_start_in;
         loop_index_ff <= loop_index_in;
         if (csr_write) begin
            case (csr_index)
               REG_FORMAT_VERSION: version_ff  <= csr_pwdata[15:0];
               REG_DATA_OFFSET:    data_off_ff <= csr_pwdata;
               REG_LOOP_OFFSET:    loop_off_ff <= csr_pwdata;
               default:            version_ff  <= version_ff;
            endcase
         end
      end
   end

   assign cfg.ext_operands = (version_ff >= VER_EXT_OPERANDS);
   assign cfg.loop_enabled = (loop_off_ff != 32'd0);
   assign cfg.data_start   = data_start_ff;
   assign cfg.loop_index   = loop_index_ff;

   vcsd_front u_front (
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .ext_operands   (cfg.ext_operands),
      .q_full         (cmd_full),
      .q_push         (front_push),
      .q_data         (front_data)
   );

   vcsd_queue #(
      .WIDTH ($bits(cmd_entry_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (cmd_empty)
   );

   vcsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (back_push),
      .rsp_data  (back_data)
   );

   vcsd_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_command        = rsp_data.command;
   assign rsp_chip_port      = rsp_data.chip_port;
   assign rsp_reg_address    = rsp_data.reg_address;
   assign rsp_reg_data       = rsp_data.reg_data;
   assign rsp_wait_count     = rsp_data.wait_count;
   assign rsp_wide_value     = rsp_data.wide_value;
   assign rsp_block_position = rsp_data.block_position;

endmodule
`default_nettype wire
